// File: design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: request and response
// transfer formats, opcodes and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package pal_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_GET    = 3'd3,
		OP_LOCATE = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         position;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] value_out;
		logic [5:0]         found_position;
		logic [5:0]         list_length;
		logic               is_empty;
	} rsp_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic capture; // latch hit/select flags for a new request
		logic ins;     // open a slot at the selected position
		logic del;     // close the slot at the selected position
	} cell_ctrl_t;

endpackage

// File: design/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Holds one entry, flags whether it matches the search key or
// sits at the requested position, and takes its neighbor's entry on shifts.
// ----------------------------------------------------------------------------
module pal_cell #(
	parameter int IDX = 0,
	parameter int PW  = 6,
	parameter int CW  = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pal_pkg::cell_ctrl_t     ctrl,
	input  logic [PW-1:0]           pos,
	input  logic [CW-1:0]           count,
	input  logic signed [31:0]      key,
	input  logic signed [31:0]      wdata,
	input  logic signed [31:0]      left,
	input  logic signed [31:0]      right,
	output logic signed [31:0]      entry,
	output logic                    hit,
	output logic                    sel
);

	logic signed [31:0] entry_q;
	logic               hit_q;
	logic               sel_q;
	logic               ge_q;

	// Flags for the request in flight; position is 1-based.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			sel_q <= 1'b0;
			ge_q  <= 1'b0;
		end else if (ctrl.capture) begin
			hit_q <= (entry_q == key) && (CW'(IDX) < count);
			sel_q <= (PW'(IDX + 1) == pos);
			ge_q  <= (PW'(IDX + 1) >= pos);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (sel_q) begin
				entry_q <= wdata;
			end else if (ge_q) begin
				entry_q <= left;
			end
		end else if (ctrl.del && ge_q) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;
	assign sel   = sel_q;

endmodule

// File: design/pal_reduce.sv
// ----------------------------------------------------------------------------
// pal_reduce
// Collapses the per-cell flags: reads the selected entry and encodes the
// lowest matching slot as a 1-based position (0 when nothing matches).
// ----------------------------------------------------------------------------
module pal_reduce #(
	parameter int CAPACITY = 32,
	parameter int CW       = 6
) (
	input  logic [CAPACITY-1:0]              sel,
	input  logic [CAPACITY-1:0]              hit,
	input  logic [CAPACITY-1:0][31:0]        data,
	output logic signed [31:0]               rdata,
	output logic [CW-1:0]                    found
);

	logic [CAPACITY-1:0] first;

	// Isolate the lowest set match bit.
	assign first = hit & (~hit + CAPACITY'(1));

	always_comb begin
		rdata = '0;
		found = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (sel[i]) begin
				rdata = rdata | data[i];
			end
			if (first[i]) begin
				found = found | CW'(i + 1);
			end
		end
	end

endmodule

// File: design/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed 32-bit values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Response path: a request transfer is held in the flight stage (valid_s1)
//   and retires into the output register once that is free or being drained.
// Flow: one request at a time; the cell row captures its flags on the
//   transfer and shifts on retire, and only then takes a new request.
// Reset: list length returns to zero and both channels go idle; entry
//   contents are not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
module positional_array_list_core #(
	parameter int CAPACITY = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pal_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;

	// Request in flight between capture and shift.
	logic               valid_s1;
	pal_pkg::op_t       op_s1;
	logic               ok_s1;
	logic signed [31:0] val_s1;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               rsp_valid_q;
	pal_pkg::rsp_t      rsp_q;

	logic               req_xfer;
	logic               advance;
	logic [PW-1:0]      pos_w;
	logic               ins_ok;
	logic               rd_ok;
	logic               ok_now;
	pal_pkg::op_t       op_now;

	pal_pkg::cell_ctrl_t         ctrl;
	logic [CAPACITY-1:0][31:0]   entries;
	logic [CAPACITY-1:0]         hits;
	logic [CAPACITY-1:0]         sels;
	logic signed [31:0]          rdata;
	logic [CW-1:0]               found;
	logic [PW-1:0]               cnt_ext;
	logic [PW-1:0]               found_ext;
	pal_pkg::rsp_t               rsp_next;

	// Take a new request only while the cell row is free.
	assign req_stall = valid_s1;
	assign req_xfer  = req_valid && !req_stall;
	// Retire into the output register once it is free or being drained.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);

	// Range checks against the length before the operation.
	assign pos_w  = PW'(req.position);
	assign op_now = pal_pkg::op_t'(req.opcode);
	assign ins_ok = (count_q < CW'(CAPACITY)) && (pos_w != '0)
		&& ({1'b0, pos_w} <= ((PW + 1)'(count_q) + (PW + 1)'(1)));
	assign rd_ok  = (pos_w != '0) && (pos_w <= PW'(count_q));

	always_comb begin
		case (op_now) inside
			pal_pkg::OP_INSERT:                    ok_now = ins_ok;
			pal_pkg::OP_DELETE, pal_pkg::OP_GET:   ok_now = rd_ok;
			pal_pkg::OP_CLEAR, pal_pkg::OP_LOCATE: ok_now = 1'b1;
			default:                               ok_now = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1  <= op_now;
			ok_s1  <= ok_now;
			val_s1 <= req.value_in;
		end
	end

	// Broadcast the command to the row: capture on transfer, shift on retire.
	assign ctrl.capture = req_xfer;
	assign ctrl.ins     = advance && ok_s1 && (op_s1 == pal_pkg::OP_INSERT);
	assign ctrl.del     = advance && ok_s1 && (op_s1 == pal_pkg::OP_DELETE);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;
		logic signed [31:0] entry_d;

		// Ends of the row: the head never shifts up into itself, the tail
		// keeps its own entry on a close.
		if (i == 0) begin : g_head
			assign left_d = val_s1;
		end else begin : g_body_l
			assign left_d = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = entry_d;
		end else begin : g_body_r
			assign right_d = entries[i+1];
		end

		pal_cell #(
			.IDX (i),
			.PW  (PW),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.pos    (pos_w),
			.count  (count_q),
			.key    (req.value_in),
			.wdata  (val_s1),
			.left   (left_d),
			.right  (right_d),
			.entry  (entry_d),
			.hit    (hits[i]),
			.sel    (sels[i])
		);

		assign entries[i] = entry_d;
	end

	pal_reduce #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_reduce (
		.sel   (sels),
		.hit   (hits),
		.data  (entries),
		.rdata (rdata),
		.found (found)
	);

	// Length after the operation.
	always_comb begin
		count_next = count_q;
		if (op_s1 == pal_pkg::OP_CLEAR) begin
			count_next = '0;
		end else if (ok_s1 && (op_s1 == pal_pkg::OP_INSERT)) begin
			count_next = count_q + CW'(1);
		end else if (ok_s1 && (op_s1 == pal_pkg::OP_DELETE)) begin
			count_next = count_q - CW'(1);
		end
	end

	assign cnt_ext   = PW'(count_next);
	assign found_ext = PW'(found);

	// Assemble the response; fields without meaning read as zero.
	always_comb begin
		rsp_next                = '0;
		rsp_next.list_length    = cnt_ext[5:0];
		rsp_next.is_empty       = (count_next == '0);
		unique case (op_s1) inside
			pal_pkg::OP_CLEAR: begin
				rsp_next.status = 1'b0;
			end
			pal_pkg::OP_INSERT: begin
				rsp_next.status = !ok_s1;
			end
			pal_pkg::OP_DELETE, pal_pkg::OP_GET: begin
				rsp_next.status    = !ok_s1;
				rsp_next.value_out = ok_s1 ? rdata : '0;
			end
			pal_pkg::OP_LOCATE: begin
				rsp_next.status         = 1'b0;
				rsp_next.found_position = found_ext[5:0];
			end
			default: begin
				rsp_next.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response while stalled.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == pal_pkg::OP_CLEAR |=> count_q == '0 && rsp.is_empty)
		else $error("clear left entries behind");

	a_no_shift_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.ins || ctrl.del) |-> valid_s1 && !(ctrl.ins && ctrl.del))
		else $error("cell shift without a request in flight");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_array_list_core. A short directed list
// hits the edge cases (empty list, bad positions, extreme values, duplicates,
// spare opcodes); random traffic follows, grouped into runs that grow,
// shrink or scramble the list. A local list model predicts every response,
// and the monitor compares each response transfer field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIST_DEPTH = 32;
	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LOG_LIMIT = 100;
	localparam int POOL_SIZE = 16;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam logic ST_ERR = 1'b1;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} mix_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	pal_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	pal_pkg::rsp_t  rsp;

	// stimulus side
	pal_pkg::req_t pending_reqs[$];
	int   total_reqs = 0;
	int   shadow_len = 0;
	logic signed [31:0] value_pool [POOL_SIZE];

	// list model and expected responses
	logic signed [31:0] model_store [LIST_DEPTH];
	int   model_len = 0;
	pal_pkg::rsp_t expected_rsps[$];

	// bookkeeping
	logic req_fire = 1'b0;
	int   sent_count = 0;
	int   rsp_count = 0;
	int   idle_cycles = 0;
	int   fail_count = 0;
	int   tx_idle_pct;
	int   rx_idle_pct;

	positional_array_list_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Queue one request and track the list length it leaves behind, so the
	// generator can aim positions at the live range.
	function automatic void queue_request(input logic [2:0] op, input int pos,
			input logic signed [31:0] val);
		pal_pkg::req_t r;
		r.opcode = op;
		r.position = pos[5:0];
		r.value_in = val;
		pending_reqs.push_back(r);
		total_reqs++;
		if (op == pal_pkg::OP_CLEAR)
			shadow_len = 0;
		else if (op == pal_pkg::OP_INSERT && shadow_len < LIST_DEPTH && pos >= 1
				&& pos <= shadow_len + 1)
			shadow_len++;
		else if (op == pal_pkg::OP_DELETE && pos >= 1 && pos <= shadow_len)
			shadow_len--;
	endfunction

	// Apply one request to the list model and return the response it yields.
	function automatic pal_pkg::rsp_t predict_list_op(input pal_pkg::req_t r);
		pal_pkg::rsp_t e;
		int   p;
		int   k;
		logic hit;
		e = '0;
		p = int'(r.position);
		hit = 1'b0;
		case (r.opcode)
			pal_pkg::OP_CLEAR: begin
				model_len = 0;
			end
			pal_pkg::OP_INSERT: begin
				if (model_len >= LIST_DEPTH || p < 1 || p > model_len + 1) begin
					e.status = ST_ERR;
				end else begin
					// open the slot, highest entry first
					for (k = model_len; k > p - 1; k--)
						model_store[k] = model_store[k - 1];
					model_store[p - 1] = r.value_in;
					model_len++;
				end
			end
			pal_pkg::OP_DELETE: begin
				if (p < 1 || p > model_len) begin
					e.status = ST_ERR;
				end else begin
					e.value_out = model_store[p - 1];
					for (k = p; k < model_len; k++)
						model_store[k - 1] = model_store[k];
					model_len--;
				end
			end
			pal_pkg::OP_GET: begin
				if (p < 1 || p > model_len)
					e.status = ST_ERR;
				else
					e.value_out = model_store[p - 1];
			end
			pal_pkg::OP_LOCATE: begin
				// first match wins
				for (k = 0; k < model_len; k++) begin
					if (!hit && model_store[k] == r.value_in) begin
						hit = 1'b1;
						e.found_position = 6'(k + 1);
					end
				end
			end
			default: begin
				e.status = ST_ERR;
			end
		endcase
		e.list_length = 6'(model_len);
		e.is_empty = (model_len == 0);
		return e;
	endfunction

	// Print one line per mismatch (bounded) and count every one.
	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= LOG_LIMIT)
			$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic check_response(input pal_pkg::rsp_t got);
		pal_pkg::rsp_t want;
		if (expected_rsps.size() == 0) begin
			report_mismatch("response transfer with nothing outstanding");
			return;
		end
		want = expected_rsps.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("rsp %0d status %b, expected %b",
				rsp_count, got.status, want.status));
		if (got.value_out !== want.value_out)
			report_mismatch($sformatf("rsp %0d value_out %h, expected %h",
				rsp_count, got.value_out, want.value_out));
		if (got.found_position !== want.found_position)
			report_mismatch($sformatf("rsp %0d found_position %0d, expected %0d",
				rsp_count, got.found_position, want.found_position));
		if (got.list_length !== want.list_length)
			report_mismatch($sformatf("rsp %0d list_length %0d, expected %0d",
				rsp_count, got.list_length, want.list_length));
		if (got.is_empty !== want.is_empty)
			report_mismatch($sformatf("rsp %0d is_empty %b, expected %b",
				rsp_count, got.is_empty, want.is_empty));
	endtask

	// Idle mix by progress: quick sender with a busy receiver first, then the
	// reverse, then both sides flat out.
	always_comb begin
		if (sent_count < total_reqs / 3) begin
			tx_idle_pct = 31;
			rx_idle_pct = 86;
		end else if (sent_count < (2 * total_reqs) / 3) begin
			tx_idle_pct = 86;
			rx_idle_pct = 31;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	end

	// Driver: change inputs on the falling edge only.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_stall <= 1'b0;
		end else begin
			if (req_valid && !req_fire) begin
				// hold the stalled transfer as it is
			end else if (pending_reqs.size() > 0
					&& $urandom_range(99) >= tx_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_reqs.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Monitor: sample on the rising edge, check responses before predicting
	// the request taken on the same edge so a stray response cannot pair with it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_fire <= 1'b0;
			sent_count <= 0;
			idle_cycles <= 0;
		end else begin
			req_fire <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				check_response(rsp);
				rsp_count++;
			end
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(predict_list_op(req));
				sent_count <= sent_count + 1;
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: too long without any transfer means the block is stuck.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int   made;
		int   run_len;
		int   roll;
		int   pos;
		int   hi;
		int   i;
		mix_t mode;
		logic [2:0] op;
		logic signed [31:0] val;

		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		for (i = 5; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		// Directed: empty-list errors, range edges, extremes, duplicates.
		queue_request(pal_pkg::OP_GET, 1, 0);
		queue_request(pal_pkg::OP_DELETE, 1, 0);
		queue_request(pal_pkg::OP_LOCATE, 0, 0);
		queue_request(pal_pkg::OP_INSERT, 0, 32'sd5);
		queue_request(pal_pkg::OP_INSERT, 2, 32'sd5);
		queue_request(pal_pkg::OP_INSERT, 1, VAL_MIN);
		queue_request(pal_pkg::OP_INSERT, 2, VAL_MAX);
		queue_request(pal_pkg::OP_INSERT, 1, '0);
		queue_request(pal_pkg::OP_INSERT, 4, -32'sd1);
		queue_request(pal_pkg::OP_INSERT, 63, VAL_MAX);
		queue_request(pal_pkg::OP_GET, 1, 0);
		queue_request(pal_pkg::OP_GET, 4, 0);
		queue_request(pal_pkg::OP_GET, 5, 0);
		queue_request(pal_pkg::OP_GET, 0, 0);
		queue_request(pal_pkg::OP_LOCATE, 0, VAL_MAX);
		queue_request(pal_pkg::OP_LOCATE, 63, 32'sd12345);
		queue_request(pal_pkg::OP_INSERT, 2, VAL_MAX);
		queue_request(pal_pkg::OP_LOCATE, 0, VAL_MAX);
		queue_request(pal_pkg::OP_DELETE, 2, 0);
		queue_request(pal_pkg::OP_DELETE, 5, 0);
		queue_request(pal_pkg::OP_DELETE, 4, 0);
		for (op = OP_SPARE_FIRST; op != pal_pkg::OP_CLEAR; op++)
			queue_request(op, $urandom_range(63), $urandom);
		queue_request(pal_pkg::OP_CLEAR, 0, 0);
		queue_request(pal_pkg::OP_GET, 1, 0);

		// Random runs. Open with a long growing run so the list fills.
		made = 0;
		mode = MODE_GROW;
		run_len = 70;
		while (made < RANDOM_ITEMS) begin
			for (i = 0; i < run_len && made < RANDOM_ITEMS; i++) begin
				roll = $urandom_range(99);
				case (mode)
					MODE_GROW:
						op = roll < 70 ? pal_pkg::OP_INSERT
							: roll < 80 ? pal_pkg::OP_GET
							: roll < 92 ? pal_pkg::OP_LOCATE : pal_pkg::OP_DELETE;
					MODE_SHRINK:
						op = roll < 55 ? pal_pkg::OP_DELETE
							: roll < 70 ? pal_pkg::OP_INSERT
							: roll < 82 ? pal_pkg::OP_GET
							: roll < 94 ? pal_pkg::OP_LOCATE
							: roll < 97 ? pal_pkg::OP_CLEAR : OP_SPARE_FIRST;
					MODE_MIXED:
						op = roll < 35 ? pal_pkg::OP_INSERT
							: roll < 58 ? pal_pkg::OP_DELETE
							: roll < 75 ? pal_pkg::OP_GET
							: roll < 93 ? pal_pkg::OP_LOCATE
							: roll < 97 ? pal_pkg::OP_CLEAR : OP_SPARE_LAST;
					default:
						op = roll < 30 ? 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))
							: roll < 35 ? pal_pkg::OP_CLEAR
							: 3'($urandom_range(pal_pkg::OP_INSERT, pal_pkg::OP_LOCATE));
				endcase
				// mostly legal positions; noise runs mostly arbitrary ones
				hi = (op == pal_pkg::OP_INSERT) ? shadow_len + 1 : shadow_len;
				if (hi >= 1 && $urandom_range(99) < (mode == MODE_NOISE ? 30 : 88))
					pos = $urandom_range(hi, 1);
				else
					pos = $urandom_range(63);
				if ($urandom_range(1))
					val = value_pool[$urandom_range(POOL_SIZE - 1)];
				else
					val = $urandom;
				queue_request(op, pos, val);
				made++;
			end
			roll = $urandom_range(9);
			mode = roll < 4 ? MODE_GROW : roll < 7 ? MODE_SHRINK
				: roll < 9 ? MODE_MIXED : MODE_NOISE;
			run_len = $urandom_range(60, 20);
		end

		// Reset once; release on a falling edge, away from sampling.
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go out and every response to come back.
		while (sent_count < total_reqs)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_rsps.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived",
				expected_rsps.size()));
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
